// ===== design/acm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acm_pkg: shared types, constants and AES helper functions
// Holds the S-box, round primitives and the classified-item record.
// ----------------------------------------------------------------------------
package acm_pkg;

  localparam int QueueDepth = 2;
  localparam int NumRounds  = 14;

  // Configuration register indexes.
  localparam logic [1:0] REG_KEY0 = 2'd0;
  localparam logic [1:0] REG_KEY1 = 2'd1;
  localparam logic [1:0] REG_KEY2 = 2'd2;
  localparam logic [1:0] REG_KEY3 = 2'd3;

  // Subkey selection for a classified block.
  localparam logic [1:0] SK_NONE = 2'd0;
  localparam logic [1:0] SK_K1   = 2'd1;
  localparam logic [1:0] SK_K2   = 2'd2;

  // One classified item handed from the front to the back.
  typedef struct packed {
    logic [127:0] data;
    logic         last;
    logic [1:0]   subkey;
  } item_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // One AES round without the round key; byte 0 is bits 127:120.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic mix);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] x;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = sbox(s[127 - 8*i -: 8]);
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++) t[i + 4*c] = b[i + 4*((c + i) % 4)];
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        x = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
        r[127 - 32*c -: 8] = t[4*c]   ^ x ^ xtime(t[4*c]   ^ t[4*c+1]);
        r[119 - 32*c -: 8] = t[4*c+1] ^ x ^ xtime(t[4*c+1] ^ t[4*c+2]);
        r[111 - 32*c -: 8] = t[4*c+2] ^ x ^ xtime(t[4*c+2] ^ t[4*c+3]);
        r[103 - 32*c -: 8] = t[4*c+3] ^ x ^ xtime(t[4*c+3] ^ t[4*c]);
      end
    end else begin
      for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = t[i];
    end
    return r;
  endfunction

  function automatic logic [127:0] gf_double(input logic [127:0] v);
    return {v[126:0], 1'b0} ^ {120'd0, (v[127] ? 8'h87 : 8'h00)};
  endfunction

endpackage

// ===== design/acm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acm_front: input classification and pad queue
// Masks and pads a partial last block, tags each item's subkey and queues it.
// ----------------------------------------------------------------------------
module acm_front #(
  parameter int Depth = acm_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic [63:0]     block_high,
  input  logic [63:0]     block_low,
  input  logic            final_block,
  input  logic [4:0]      valid_bytes,
  output logic            q_valid,
  input  logic            q_take,
  output acm_pkg::item_t  q_item
);
  import acm_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  item_t           slots [Depth];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  item_t           cls;
  logic [4:0]      n;
  logic [127:0]    blk;
  logic            do_push;
  logic            do_pop;

  // Classify the incoming block: mask, pad and choose the subkey.
  always_comb begin
    blk = {block_high, block_low};
    n   = (valid_bytes > 5'd16) ? 5'd16 : valid_bytes;
    cls.last = final_block;
    if (!final_block) begin
      cls.data   = blk;
      cls.subkey = SK_NONE;
    end else if (n == 5'd16) begin
      cls.data   = blk;
      cls.subkey = SK_K1;
    end else begin
      for (int i = 0; i < 16; i++) begin
        if (i < int'(n)) cls.data[127 - 8*i -: 8] = blk[127 - 8*i -: 8];
        else if (i == int'(n)) cls.data[127 - 8*i -: 8] = 8'h80;
        else cls.data[127 - 8*i -: 8] = 8'h00;
      end
      cls.subkey = SK_K2;
    end
  end

  assign full    = (count == CW'(Depth));
  assign q_valid = (count != '0);
  assign q_item  = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  // Small circular queue between front and back.
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= cls;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

// ===== design/acm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acm_back: key schedule, subkey derivation and CBC-MAC engine
// One AES round per cycle; round keys are generated on the fly.
// ----------------------------------------------------------------------------
module acm_back (
  input  logic            clk,
  input  logic            rst,
  input  logic [255:0]    key,
  input  logic            rekey,
  input  logic            q_valid,
  output logic            q_take,
  input  acm_pkg::item_t  q_item,
  output logic            empty,
  input  logic            pop,
  output logic [63:0]     tag_high,
  output logic [63:0]     tag_low
);
  import acm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_SUB   = 2'd2;

  logic [1:0]   state;
  logic [3:0]   round;
  logic         busy_sub;
  logic         need_sub;
  logic         cur_last;
  logic [127:0] st;
  logic [127:0] chain;
  logic [127:0] k1;
  logic [127:0] k2;
  logic [255:0] kw;
  logic [255:0] kw_next;
  logic [127:0] st_round;
  logic [127:0] in_x;
  logic [127:0] sk;
  logic [31:0]  t0;
  logic [31:0]  t4;
  logic [7:0]   rc;
  logic [127:0] res_hold;
  logic         res_valid;

  // Advance the key window by one round (eight words form two rounds).
  // An even round rotates the newest word and adds the round constant;
  // an odd round passes the newest word through the S-box alone.
  always_comb begin
    case (round[3:1])
      3'd0: rc = 8'h01; 3'd1: rc = 8'h02; 3'd2: rc = 8'h04; 3'd3: rc = 8'h08;
      3'd4: rc = 8'h10; 3'd5: rc = 8'h20; 3'd6: rc = 8'h40;
      default: rc = 8'h00;
    endcase
    t0 = sub_word({kw[23:0], kw[31:24]}) ^ {rc, 24'd0};
    t4 = sub_word(kw[31:0]);
    kw_next[255:128] = kw[127:0];
    kw_next[127:96]  = kw[255:224] ^ (round[0] ? t4 : t0);
    kw_next[95:64]   = kw[223:192] ^ kw_next[127:96];
    kw_next[63:32]   = kw[191:160] ^ kw_next[95:64];
    kw_next[31:0]    = kw[159:128] ^ kw_next[63:32];
  end

  assign st_round = aes_round(st, round != 4'(NumRounds - 1)) ^ kw_next[255:128];

  always_comb begin
    case (q_item.subkey)
      SK_K1:   sk = k1;
      SK_K2:   sk = k2;
      default: sk = '0;
    endcase
    in_x = chain ^ q_item.data ^ sk;
  end

  assign q_take   = (state == ST_IDLE) && !need_sub && !rekey && q_valid &&
                    !(q_item.last && res_valid);
  assign empty    = !res_valid;
  assign tag_high = res_hold[127:64];
  assign tag_low  = res_hold[63:0];

  // Sequencer: subkey derivation first after a key change, then blocks.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      need_sub  <= 1'b1;
      res_valid <= 1'b0;
      chain     <= '0;
      round     <= '0;
      busy_sub  <= 1'b0;
      cur_last  <= 1'b0;
    end else begin
      if (pop && res_valid) res_valid <= 1'b0;
      if (rekey) need_sub <= 1'b1;
      case (state)
        ST_IDLE: begin
          if (need_sub && !rekey) begin
            st       <= key[255:128];
            kw       <= key;
            round    <= '0;
            busy_sub <= 1'b1;
            need_sub <= 1'b0;
            state    <= ST_RUN;
          end else if (q_take) begin
            st       <= in_x ^ key[255:128];
            kw       <= key;
            round    <= '0;
            busy_sub <= 1'b0;
            cur_last <= q_item.last;
            state    <= ST_RUN;
          end
        end
        ST_RUN: begin
          st <= st_round;
          kw <= kw_next;
          round <= round + 4'd1;
          if (round == 4'(NumRounds - 1)) state <= ST_SUB;
        end
        ST_SUB: begin
          state <= ST_IDLE;
          if (busy_sub) begin
            k1 <= gf_double(st);
            k2 <= gf_double(gf_double(st));
          end else if (cur_last) begin
            res_hold  <= st;
            res_valid <= 1'b1;
            chain     <= '0;
          end else begin
            chain <= st;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== design/aes256_cmac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes256_cmac: AES-CMAC with a 256-bit key, one 16-byte block per transfer
// Front classifies and pads blocks into a queue; back runs the AES rounds.
// ----------------------------------------------------------------------------
// Each block passes through the AES engine as one load, 14 rounds and one
// write-back; the single round unit runs the rounds one after another.
// A tag is ready once its final block has finished the write-back step.
// Subkey derivation runs after reset and again after every key write.
// Reset clears the key to zero and the chaining value.
module aes256_cmac #(
  parameter int QDepth = acm_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  input  logic        final_block,
  input  logic [4:0]  valid_bytes,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] tag_high,
  output logic [63:0] tag_low
);
  import acm_pkg::*;

  logic [63:0] key_words [4];
  logic        wr_en;
  logic        rekey;
  logic        q_valid;
  logic        q_take;
  item_t       q_item;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite && pready;

  // Key register file; any write restarts the subkey derivation.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) key_words[i] <= '0;
      rekey <= 1'b0;
    end else begin
      rekey <= wr_en;
      if (wr_en) key_words[reg_idx] <= pwdata;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KEY0: prdata = key_words[0];
      REG_KEY1: prdata = key_words[1];
      REG_KEY2: prdata = key_words[2];
      REG_KEY3: prdata = key_words[3];
      default:  prdata = '0;
    endcase
  end

  acm_front #(.Depth(QDepth)) u_front (
    .clk, .rst, .push, .full, .block_high, .block_low, .final_block,
    .valid_bytes, .q_valid, .q_take, .q_item
  );

  acm_back u_back (
    .clk, .rst,
    .key({key_words[0], key_words[1], key_words[2], key_words[3]}),
    .rekey, .q_valid, .q_take, .q_item, .empty, .pop, .tag_high, .tag_low
  );

endmodule
